// ===== hw/rtl/fyse_pkg.sv =====
// Shared types and constants of the Fisher-Yates shuffle engine.
// Depends on nothing; the engine and the remainder unit use it by scoped names.
`default_nettype none

package fyse_pkg;

	localparam int DEPTH_DEF   = 1024;
	localparam int DATA_W      = 32;
	localparam int RND_W       = 31;
	localparam int IDX_W       = 10;
	localparam int REQ_W       = 2;
	localparam int ARR_LEN_W   = 11;
	localparam int ARR_LEN_RST = 1024;
	localparam int PADDR_W     = 3;

	// Remainder unit: dividend width and quotient bits resolved per cycle.
	localparam int DVD_W    = 32;
	localparam int DIV_BITS = 8;
	localparam int DIV_ITER = DVD_W / DIV_BITS;

	typedef logic [REQ_W-1:0] req_code_t;
	localparam req_code_t REQ_LOAD = 2'd0;
	localparam req_code_t REQ_STEP = 2'd1;
	localparam req_code_t REQ_READ = 2'd2;

	// Register index, taken from bit 2 of the byte address.
	localparam logic REG_ARRAY_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_WRI,
		ST_WRJ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [DATA_W-1:0] load_value;
		logic [RND_W-1:0]         random_word;
		logic [IDX_W-1:0]         read_index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [IDX_W-1:0]         swap_partner;
		logic                     shuffle_done;
		logic                     status;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fyse_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Used for the request and response channels of the shuffle engine.
`default_nettype none

interface fyse_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fisher_yates_shuffle_engine.sv =====
// Fisher-Yates shuffle engine: element store, shuffle sequencer and APB register.
// Requests are taken only in the idle state; a step waits for the remainder unit (four
// iterations) and makes its two swap writes through the single write port. Reset clears
// the control state and sets array_length to 1024; the store holds no defined contents
// after reset and has no clearing pass.
`default_nettype none

module fisher_yates_shuffle_engine #(
	parameter int DEPTH = fyse_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fyse_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	fyse_stream_if.sink                        req,
	fyse_stream_if.source                      rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > fyse_pkg::ARR_LEN_W) ? LW : fyse_pkg::ARR_LEN_W;
	localparam int LEN_RST = (fyse_pkg::ARR_LEN_RST > DEPTH) ? DEPTH : fyse_pkg::ARR_LEN_RST;
	localparam int RSH   = fyse_pkg::IDX_W + IW;
	localparam int RCP_W = fyse_pkg::IDX_W + 2;
	localparam int PW    = fyse_pkg::IDX_W + RCP_W;
	localparam longint unsigned RCP = ((64'd1 << RSH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

	fyse_pkg::state_t state_q, state_nx;

	logic [fyse_pkg::ARR_LEN_W-1:0] arr_len_q;
	logic [LW-1:0]                  len_q;
	logic [LW-1:0]                  lp_q;
	logic [IW-1:0]                  pos_q;
	logic [IW-1:0]                  j_q;
	fyse_pkg::req_code_t            req_code_q;
	logic                           ign_q;
	fyse_pkg::rsp_t                 out_q;
	logic                           out_vld_q;

	logic                   cfg_wr;
	logic [CW-1:0]          len_raw;
	logic [LW-1:0]          len_nx;
	logic                   accept;
	logic                   in_load, in_step, in_read;
	logic                   load_ok, step_ok;
	logic                   div_start, div_done;
	logic [fyse_pkg::DVD_W-1:0] div_dvd;
	logic [LW-1:0]          div_dsr;
	logic [LW-1:0]          div_rem;
	logic                   out_load;
	logic [IW+9:0]          j_wide;
	logic [PW-1:0]          rd_prod;
	logic [PW-1:0]          rd_quo;
	logic [IW-1:0]          rd_idx;

	logic                         mem_we, mem_re;
	logic [IW-1:0]                mem_wa, mem_ra, mem_rb;
	logic [fyse_pkg::DATA_W-1:0] mem_wd;
	logic [fyse_pkg::DATA_W-1:0] mem [DEPTH];
	logic [fyse_pkg::DATA_W-1:0] rd_a_q, rd_b_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready &&
	                 (paddr[2] == fyse_pkg::REG_ARRAY_LENGTH);
	assign prdata  = (paddr[2] == fyse_pkg::REG_ARRAY_LENGTH) ?
	                 32'(arr_len_q) : 32'd0;
	assign len_raw = CW'(pwdata[fyse_pkg::ARR_LEN_W-1:0]);

	always_comb begin
		if (len_raw == '0) begin
			len_nx = LW'(1);
		end else if (len_raw > CW'(DEPTH)) begin
			len_nx = LW'(DEPTH);
		end else begin
			len_nx = LW'(len_raw);
		end
	end

	// Request decode.
	assign accept  = req.valid && req.ready;
	assign in_load = (req.payload.req_type == fyse_pkg::REQ_LOAD);
	assign in_step = (req.payload.req_type == fyse_pkg::REQ_STEP);
	assign in_read = (req.payload.req_type == fyse_pkg::REQ_READ);
	assign load_ok = (lp_q < len_q);
	assign step_ok = (pos_q != '0);

	// The read index is reduced modulo DEPTH by a reciprocal multiplication.
	assign rd_prod = PW'(req.payload.read_index) * PW'(RCP);
	assign rd_quo  = rd_prod >> RSH;
	assign rd_idx  = IW'(PW'(req.payload.read_index) - rd_quo * PW'(DEPTH));

	assign div_dvd = fyse_pkg::DVD_W'(req.payload.random_word);
	assign div_dsr = LW'(pos_q) + LW'(1);

	fyse_mod_unit #(
		.DW (LW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			fyse_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (in_step && step_ok) begin
						state_nx = fyse_pkg::ST_DIV;
					end else if (in_read) begin
						state_nx = fyse_pkg::ST_READ;
					end else begin
						state_nx = fyse_pkg::ST_DONE;
					end
				end
			end
			fyse_pkg::ST_DIV: begin
				if (div_done) begin
					state_nx = fyse_pkg::ST_READ;
				end
			end
			fyse_pkg::ST_READ: begin
				if (req_code_q == fyse_pkg::REQ_STEP) begin
					state_nx = fyse_pkg::ST_WRI;
				end else begin
					state_nx = fyse_pkg::ST_DONE;
				end
			end
			fyse_pkg::ST_WRI: state_nx = fyse_pkg::ST_WRJ;
			fyse_pkg::ST_WRJ: state_nx = fyse_pkg::ST_DONE;
			fyse_pkg::ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					state_nx = fyse_pkg::ST_IDLE;
				end
			end
			default: state_nx = fyse_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req.ready = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wa    = pos_q;
		mem_wd    = rd_b_q;
		mem_ra    = pos_q;
		mem_rb    = j_q;
		out_load  = 1'b0;
		case (state_q)
			fyse_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				div_start = req.valid && in_step && step_ok;
				mem_we    = req.valid && in_load && load_ok;
				mem_wa    = lp_q[IW-1:0];
				mem_wd    = req.payload.load_value;
			end
			fyse_pkg::ST_READ: begin
				mem_re = 1'b1;
				if (req_code_q != fyse_pkg::REQ_STEP) begin
					mem_ra = j_q;
				end
			end
			fyse_pkg::ST_WRI: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = rd_b_q;
			end
			fyse_pkg::ST_WRJ: begin
				mem_we = 1'b1;
				mem_wa = j_q;
				mem_wd = rd_a_q;
			end
			fyse_pkg::ST_DONE: begin
				out_load = !out_vld_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	// Element store: one write port, two read ports, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_a_q <= mem[mem_ra];
			rd_b_q <= mem[mem_rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fyse_pkg::ST_IDLE;
			arr_len_q <= fyse_pkg::ARR_LEN_W'(fyse_pkg::ARR_LEN_RST);
			len_q     <= LW'(LEN_RST);
			lp_q      <= '0;
			pos_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) begin
				arr_len_q <= pwdata[fyse_pkg::ARR_LEN_W-1:0];
				len_q     <= len_nx;
				lp_q      <= '0;
				pos_q     <= '0;
			end else if (accept && in_load && load_ok) begin
				lp_q  <= lp_q + LW'(1);
				pos_q <= IW'(len_q - LW'(1));
			end else if (state_q == fyse_pkg::ST_WRJ) begin
				pos_q <= pos_q - IW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_code_q <= req.payload.req_type;
			ign_q      <= in_load ? !load_ok : in_step ? !step_ok : !in_read;
		end
		if (accept && in_read) begin
			j_q <= rd_idx;
		end else if (state_q == fyse_pkg::ST_DIV && div_done) begin
			j_q <= div_rem[IW-1:0];
		end
		if (out_load) begin
			out_q <= out_result();
		end
	end

	assign j_wide = (IW + 10)'(j_q);

	function automatic fyse_pkg::rsp_t out_result();
		fyse_pkg::rsp_t r;
		r.read_value   = (req_code_q == fyse_pkg::REQ_READ) ? $signed(rd_a_q) : '0;
		r.swap_partner = (req_code_q == fyse_pkg::REQ_STEP && !ign_q) ? j_wide[9:0] : '0;
		r.shuffle_done = (pos_q == '0);
		r.status       = ign_q;
		return r;
	endfunction

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	// The remainder unit only finishes while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == fyse_pkg::ST_DIV))
		else $error("remainder finished outside its wait state");

	// A swap never runs with the position at zero, and its partner never lies above it.
	a_swap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fyse_pkg::ST_WRI) |-> (pos_q != '0 && j_q <= pos_q))
		else $error("swap with a bad position or partner");

	// The load pointer never runs past the configured length.
	a_lp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= len_q)
		else $error("load pointer beyond length");

	// The position decrements by one across a completed swap.
	a_pos_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fyse_pkg::ST_WRJ && !cfg_wr) |=> (pos_q == $past(pos_q) - IW'(1)))
		else $error("position not decremented after swap");

endmodule

`default_nettype wire

// ===== hw/rtl/fyse_mod_unit.sv =====
// Iterative remainder unit: dividend mod divisor, several quotient bits per cycle.
// Depends on fyse_pkg for the dividend width and the bits resolved per cycle.
`default_nettype none

module fyse_mod_unit #(
	parameter int DW = $clog2(fyse_pkg::DEPTH_DEF + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [fyse_pkg::DVD_W-1:0] dividend,
	input  wire logic [DW-1:0]               divisor,
	output logic                             done,
	output logic [DW-1:0]                    remainder
);

	localparam int CNT_W = $clog2(fyse_pkg::DIV_ITER);

	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               dsr_q;
	logic [fyse_pkg::DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [DW-1:0]               rem_nx;
	logic [fyse_pkg::DVD_W-1:0] dvd_nx;

	always_comb begin
		logic [DW-1:0]               r;
		logic [fyse_pkg::DVD_W-1:0] d;
		logic [DW:0]                 t;
		logic [DW:0]                 diff;
		r = rem_q;
		d = dvd_q;
		for (int k = 0; k < fyse_pkg::DIV_BITS; k++) begin
			t    = {r, d[fyse_pkg::DVD_W-1]};
			d    = {d[fyse_pkg::DVD_W-2:0], 1'b0};
			diff = t - {1'b0, dsr_q};
			if (t >= {1'b0, dsr_q}) begin
				r = diff[DW-1:0];
			end else begin
				r = t[DW-1:0];
			end
		end
		rem_nx = r;
		dvd_nx = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(fyse_pkg::DIV_ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
